// ----- rtl/apls_pkg.sv -----
// ----------------------------------------------------------------------------
// apls_pkg
// Shared widths, codes and types for the averaged position LED sketch block.
// ----------------------------------------------------------------------------
package apls_pkg;

    localparam int SAMPLE_W    = 10;
    // Number of sample pairs averaged; must be a power of two.
    localparam int AVG_COUNT   = 32;
    localparam int AVG_SHIFT   = $clog2(AVG_COUNT);
    localparam int SUM_W       = SAMPLE_W + AVG_SHIFT;
    localparam int COUNT_W     = AVG_SHIFT;
    localparam int POS_SHIFT   = 6;
    localparam int POS_W       = 4;
    localparam int FRAME_ROWS  = 8;
    localparam int ROW_W       = $clog2(FRAME_ROWS);
    localparam int WORD_W      = 32;
    localparam int BITPOS_W    = $clog2(WORD_W);
    localparam int PRESCALE_W  = 8;

    localparam logic [WORD_W-1:0]     TOP_BIT        = 32'h8000_0000;
    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 8'd15;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [ROW_W-1:0]  row;
        logic [WORD_W-1:0] mask;
    } plot_t;

    typedef struct packed {
        plot_t plot;
        logic  clear;
    } frame_ctrl_t;

    typedef struct packed {
        logic             emit;
        logic [ROW_W-1:0] row;
    } scan_t;

endpackage

// ----- rtl/averaged_position_led_sketch_top.sv -----
// ----------------------------------------------------------------------------
// averaged_position_led_sketch_top
// Averages position samples into an 8 x 32 LED frame and scans its rows out.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock. An accepted transaction is held
// in the input register, where it updates the sums, the frame store or the scan
// counters; a tick that completes a row period loads the result register, so a
// row word passes through the input register and then the result register on
// its way to the outputs. The only stall is a tick that must emit while the
// result register still holds a row that has not been taken. The prescale_reg
// register is written with cfg_wr_en and takes effect from the next tick.
module averaged_position_led_sketch_top
    import apls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [PRESCALE_W-1:0] cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operation,
    input  logic [SAMPLE_W-1:0]   row_sample,
    input  logic [SAMPLE_W-1:0]   col_sample,
    input  logic                  tilt_left,
    input  logic                  tilt_right,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ROW_W-1:0]      row_index,
    output logic [WORD_W-1:0]     row_bits
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic                op_reg;
    logic [SAMPLE_W-1:0] row_sample_reg;
    logic [SAMPLE_W-1:0] col_sample_reg;
    logic                tilt_left_reg;
    logic                tilt_right_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [ROW_W-1:0]    row_index_reg;
    logic [WORD_W-1:0]   row_bits_reg;

    logic                in_fire;
    logic                s1_needs_out;
    logic                s1_fire;
    logic                out_load;
    logic                sample_en;
    logic                tick_en;
    plot_t               plot;
    frame_ctrl_t         frame_ctrl;
    scan_t               scan;
    logic [WORD_W-1:0]   rd_word;

    assign s1_needs_out = (op_reg == OP_TICK) && scan.emit;
    assign s1_fire      = s1_valid_reg && (!s1_needs_out || !out_valid_reg || out_ready);
    assign in_ready     = !s1_valid_reg || s1_fire;
    assign in_fire      = in_valid && in_ready;
    assign sample_en    = s1_fire && (op_reg == OP_SAMPLE);
    assign tick_en      = s1_fire && (op_reg == OP_TICK);
    assign out_load     = s1_fire && s1_needs_out;

    assign frame_ctrl.plot.valid = plot.valid && sample_en;
    assign frame_ctrl.plot.row   = plot.row;
    assign frame_ctrl.plot.mask  = plot.mask;
    assign frame_ctrl.clear      = sample_en && !tilt_left_reg && !tilt_right_reg;

    apls_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_en  (sample_en),
        .row_sample (row_sample_reg),
        .col_sample (col_sample_reg),
        .plot       (plot)
    );

    apls_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (frame_ctrl),
        .rd_row  (scan.row),
        .rd_word (rd_word)
    );

    apls_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tick_en     (tick_en),
        .scan        (scan)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg         <= operation;
            row_sample_reg <= row_sample;
            col_sample_reg <= col_sample;
            tilt_left_reg  <= tilt_left;
            tilt_right_reg <= tilt_right;
        end
        if (out_load)
        begin
            row_index_reg <= scan.row;
            row_bits_reg  <= rd_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_index = row_index_reg;
    assign row_bits  = row_bits_reg;

`ifndef SYNTH
    // A tick that completes a row period always leaves a result behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("row result not presented after a completed scan period");

    // The result carries the row the scan advanced to.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (row_index == $past(scan.row)))
        else $error("row index does not match the advanced scan row");

    // Input back-pressure only comes from an emitting tick meeting a full
    // result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_needs_out && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");
`endif

endmodule

// ----- rtl/apls_accum.sv -----
// ----------------------------------------------------------------------------
// apls_accum
// Sums sample pairs and, on the last pair of a batch, turns the averages into
// a frame row and a single-bit column mask.
// ----------------------------------------------------------------------------
module apls_accum
    import apls_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_en,
    input  logic [SAMPLE_W-1:0] row_sample,
    input  logic [SAMPLE_W-1:0] col_sample,
    output plot_t               plot
);

    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [SUM_W-1:0]    row_sum_reg;
    logic [SUM_W-1:0]    row_sum_next;
    logic [SUM_W-1:0]    col_sum_reg;
    logic [SUM_W-1:0]    col_sum_next;
    logic [SUM_W-1:0]    row_total;
    logic [SUM_W-1:0]    col_total;
    logic [SUM_W-1:0]    row_avg;
    logic [SUM_W-1:0]    col_avg;
    logic [POS_W-1:0]    row_pos;
    logic [POS_W-1:0]    col_pos;
    logic [BITPOS_W-1:0] bit_pos;
    logic                last;

    // The running sums cannot overflow because they are cleared after the
    // last pair of each batch.
    assign row_total = row_sum_reg + SUM_W'(row_sample);
    assign col_total = col_sum_reg + SUM_W'(col_sample);
    assign last      = (count_reg == COUNT_W'(AVG_COUNT - 1));

    assign row_avg = row_total >> AVG_SHIFT;
    assign col_avg = col_total >> AVG_SHIFT;
    assign row_pos = row_avg[POS_SHIFT +: POS_W];
    assign col_pos = col_avg[POS_SHIFT +: POS_W];

    // Positions 8 to 15 land in the high half of the word, 0 to 7 in the low
    // half; in both cases the frame row is the low three bits.
    assign bit_pos = {~row_pos[POS_W-1], col_pos};

    assign plot.valid = last;
    assign plot.row   = row_pos[ROW_W-1:0];
    assign plot.mask  = TOP_BIT >> bit_pos;

    always_comb
    begin
        count_next   = count_reg;
        row_sum_next = row_sum_reg;
        col_sum_next = col_sum_reg;
        if (sample_en)
        begin
            if (last)
            begin
                count_next   = '0;
                row_sum_next = '0;
                col_sum_next = '0;
            end
            else
            begin
                count_next   = count_reg + 1'b1;
                row_sum_next = row_total;
                col_sum_next = col_total;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            row_sum_reg <= '0;
            col_sum_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            row_sum_reg <= row_sum_next;
            col_sum_reg <= col_sum_next;
        end
    end

endmodule

// ----- rtl/apls_frame.sv -----
// ----------------------------------------------------------------------------
// apls_frame
// Eight-row frame store: sets one bit per plotted point, clears on a sample
// with neither tilt input set, and gives one row word to the scan.
// ----------------------------------------------------------------------------
module apls_frame
    import apls_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  frame_ctrl_t       ctrl,
    input  logic [ROW_W-1:0]  rd_row,
    output logic [WORD_W-1:0] rd_word
);

    logic [WORD_W-1:0] frame_reg  [FRAME_ROWS];
    logic [WORD_W-1:0] frame_next [FRAME_ROWS];

    // A clear in the same pass also removes the point just plotted.
    always_comb
    begin
        for (int i = 0; i < FRAME_ROWS; i++)
        begin
            if (ctrl.clear)
            begin
                frame_next[i] = '0;
            end
            else if (ctrl.plot.valid && (ctrl.plot.row == ROW_W'(i)))
            begin
                frame_next[i] = frame_reg[i] | ctrl.plot.mask;
            end
            else
            begin
                frame_next[i] = frame_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_ROWS; i++)
            begin
                frame_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < FRAME_ROWS; i++)
            begin
                frame_reg[i] <= frame_next[i];
            end
        end
    end

    assign rd_word = frame_reg[rd_row];

endmodule

// ----- rtl/apls_scan.sv -----
// ----------------------------------------------------------------------------
// apls_scan
// Tick prescaler and row scan counter, with the prescale register.
// ----------------------------------------------------------------------------
module apls_scan
    import apls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [PRESCALE_W-1:0] cfg_wr_data,
    input  logic                  tick_en,
    output scan_t                 scan
);

    logic [PRESCALE_W-1:0] prescale_reg;
    logic [PRESCALE_W-1:0] prescale_next;
    logic [PRESCALE_W-1:0] count_reg;
    logic [PRESCALE_W-1:0] count_next;
    logic [PRESCALE_W-1:0] count_inc;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;
    logic [ROW_W-1:0]      row_inc;

    // The counter wraps through zero, so a limit of zero or one below the
    // running count is reached only after the wrap.
    assign count_inc = count_reg + 1'b1;
    assign row_inc   = row_reg + 1'b1;

    assign scan.emit = (count_inc == prescale_reg);
    assign scan.row  = row_inc;

    always_comb
    begin
        prescale_next = cfg_wr_en ? cfg_wr_data : prescale_reg;
        count_next    = count_reg;
        row_next      = row_reg;
        if (tick_en)
        begin
            if (scan.emit)
            begin
                count_next = '0;
                row_next   = row_inc;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= PRESCALE_RESET;
            count_reg    <= '0;
            row_reg      <= '0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            count_reg    <= count_next;
            row_reg      <= row_next;
        end
    end

endmodule
